### hw/rtl/bpa_pkg.sv
// bpa_pkg: shared types, codes and field widths of the buddy page allocator
// used by the channel interfaces, the controller and the datapath
// no dependencies
package bpa_pkg;

	// defaults for the top level parameters
	localparam int unsigned POOL_PAGES_DEF = 4096;
	localparam int unsigned MAX_ORDER_DEF  = 10;

	// fixed field widths of the channels and the config port
	localparam int unsigned PAGE_W   = 12;
	localparam int unsigned COUNT_W  = 13;
	localparam int unsigned ORDER_W  = 4;
	localparam int unsigned STATUS_W = 2;

	// operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NO_BLOCK  = 2'd1,
		ST_ORDER_BIG = 2'd2,
		ST_NOT_ALLOC = 2'd3
	} status_t;

	// controller states
	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_A_FIND,
		S_A_UNLINK,
		S_A_SPLIT,
		S_PUSH1,
		S_PUSH2,
		S_F_CHECK,
		S_F_FREE,
		S_F_BUD,
		S_F_TEST,
		S_DONE
	} state_t;

	// datapath commands
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_SWEEP,
		CMD_LOAD,
		CMD_A_FIND,
		CMD_A_UNLINK,
		CMD_A_SPLIT,
		CMD_PUSH1,
		CMD_PUSH2,
		CMD_F_CHECK,
		CMD_F_FREE,
		CMD_F_BUD,
		CMD_F_TEST
	} cmd_t;

	// datapath status flags seen by the controller
	typedef struct packed {
		logic sweep_last;
		logic req_bad;
		logic none_found;
		logic split_more;
		logic bud_in;
		logic page_out;
		logic not_used;
		logic can_bud;
		logic merge_ok;
		logic is_free;
	} dp_stat_t;

	// per page metadata word
	typedef struct packed {
		logic [ORDER_W-1:0] ord;
		logic               used;
		logic               listed;
	} meta_t;

endpackage

### hw/rtl/bpa_chan_if.sv
// bpa_chan_if: valid/ready channel interfaces for requests and results
// depends on bpa_pkg for the field widths

// request channel
interface bpa_cmd_if;
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [bpa_pkg::ORDER_W-1:0]  order;
	logic [bpa_pkg::PAGE_W-1:0]   page_index;

	modport source (output valid, operation, order, page_index, input ready);
	modport sink (input valid, operation, order, page_index, output ready);
endinterface

// result channel
interface bpa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bpa_pkg::STATUS_W-1:0]  status;
	logic [bpa_pkg::PAGE_W-1:0]    block_index;
	logic [bpa_pkg::COUNT_W-1:0]   free_count;
	logic [bpa_pkg::COUNT_W-1:0]   used_count;

	modport source (output valid, status, block_index, free_count, used_count, input ready);
	modport sink (input valid, status, block_index, free_count, used_count, output ready);
endinterface

### hw/rtl/bpa_ctrl.sv
// bpa_ctrl: sequencing state machine of the buddy page allocator
// depends on bpa_pkg; drives commands into bpa_dp and reads its flags
module bpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              in_valid,
	input  logic              in_free,
	input  logic              out_ready,
	input  bpa_pkg::dp_stat_t stat,
	output bpa_pkg::cmd_t     cmd,
	output logic              in_ready,
	output logic              out_valid
);
	import bpa_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_SWEEP:    if (stat.sweep_last) state_d = S_IDLE;
			S_IDLE:     if (in_valid) state_d = in_free ? S_F_CHECK : S_A_FIND;
			S_A_FIND:   state_d = (stat.req_bad || stat.none_found) ? S_DONE : S_A_UNLINK;
			S_A_UNLINK: state_d = S_A_SPLIT;
			S_A_SPLIT: begin
				if (!stat.split_more) state_d = S_DONE;
				else if (stat.bud_in) state_d = S_PUSH1;
				else state_d = S_A_SPLIT;
			end
			S_PUSH1:    state_d = S_PUSH2;
			S_PUSH2:    state_d = stat.is_free ? S_DONE : S_A_SPLIT;
			S_F_CHECK:  state_d = stat.page_out ? S_DONE : S_F_FREE;
			S_F_FREE:   state_d = stat.not_used ? S_DONE : S_F_BUD;
			S_F_BUD:    state_d = stat.can_bud ? S_F_TEST : S_PUSH1;
			S_F_TEST:   state_d = stat.merge_ok ? S_F_BUD : S_PUSH1;
			S_DONE:     if (out_ready) state_d = S_IDLE;
			default:    state_d = S_SWEEP;
		endcase
		// a config write rebuilds the lists
		if (cfg_we) state_d = S_SWEEP;
	end

	// outputs
	always_comb begin
		cmd       = CMD_NONE;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_SWEEP:    cmd = CMD_SWEEP;
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd = CMD_LOAD;
			end
			S_A_FIND:   cmd = CMD_A_FIND;
			S_A_UNLINK: cmd = CMD_A_UNLINK;
			S_A_SPLIT:  cmd = CMD_A_SPLIT;
			S_PUSH1:    cmd = CMD_PUSH1;
			S_PUSH2:    cmd = CMD_PUSH2;
			S_F_CHECK:  cmd = CMD_F_CHECK;
			S_F_FREE:   cmd = CMD_F_FREE;
			S_F_BUD:    cmd = CMD_F_BUD;
			S_F_TEST:   cmd = CMD_F_TEST;
			S_DONE:     out_valid = 1'b1;
			default:    cmd = CMD_NONE;
		endcase
	end

	// an accepted request always leaves idle
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !cfg_we |=> state_q != S_IDLE)
		else $error("request accepted but controller stayed idle");

	// no transfer on either side during the clearing pass
	a_sweep_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SWEEP |-> !in_ready && !out_valid)
		else $error("channel active during clearing pass");

	// a result is only shown once the item went through the datapath
	a_done_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) != S_IDLE && $past(state_q) != S_SWEEP)
		else $error("result raised without work");

endmodule

### hw/rtl/bpa_dp.sv
// bpa_dp: datapath of the buddy page allocator: link and metadata memories,
// list heads and counts, running totals and the carving sweep
// depends on bpa_pkg; commanded by bpa_ctrl
module bpa_dp #(
	parameter int unsigned POOL_PAGES = bpa_pkg::POOL_PAGES_DEF,
	parameter int unsigned MAX_ORDER  = bpa_pkg::MAX_ORDER_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bpa_pkg::cmd_t                 cmd,
	input  logic                          cfg_we,
	input  logic [bpa_pkg::COUNT_W-1:0]   cfg_wdata,
	input  logic                          in_operation,
	input  logic [bpa_pkg::ORDER_W-1:0]   in_order,
	input  logic [bpa_pkg::PAGE_W-1:0]    in_page_index,
	output bpa_pkg::dp_stat_t             stat,
	output logic [bpa_pkg::STATUS_W-1:0]  res_status,
	output logic [bpa_pkg::PAGE_W-1:0]    res_block_index,
	output logic [bpa_pkg::COUNT_W-1:0]   res_free_count,
	output logic [bpa_pkg::COUNT_W-1:0]   res_used_count
);
	import bpa_pkg::*;

	localparam int unsigned PW     = $clog2(POOL_PAGES);
	localparam int unsigned NW     = PW + 1;
	localparam int unsigned NLISTS = MAX_ORDER + 1;
	localparam int unsigned LW     = $clog2(NLISTS);
	localparam logic [NW-1:0] NIL  = NW'(POOL_PAGES);
	localparam logic [ORDER_W-1:0] MAXO = ORDER_W'(MAX_ORDER);

	// memories
	logic [NW-1:0] next_mem [POOL_PAGES];
	logic [NW-1:0] prev_mem [POOL_PAGES];
	meta_t         meta_mem [POOL_PAGES];

	logic [NW-1:0] next_rd_q, prev_rd_q;
	meta_t         meta_rd_q;
	logic [PW-1:0] rd_addr;

	logic          nx_we, pv_we, mt_we;
	logic [PW-1:0] nx_wa, pv_wa, mt_wa;
	logic [NW-1:0] nx_wd, pv_wd;
	meta_t         mt_wd;

	// control and working registers
	logic [NW-1:0]      managed_q;
	logic               op_q;
	logic [ORDER_W-1:0] req_q, cur_q, ord_q;
	logic [PAGE_W-1:0]  page_q;
	logic [PW-1:0]      h_q, pg_q;
	logic [NW-1:0]      hold_q;
	logic [NW-1:0]      head_q  [NLISTS];
	logic [NW-1:0]      count_q [NLISTS];
	logic [NW-1:0]      free_q, used_q;
	logic [PW-1:0]      sweep_idx_q;
	logic [NW-1:0]      carve_next_q, carve_left_q;
	status_t            res_status_q;
	logic [PW-1:0]      res_blk_q;

	// combinational helpers
	logic               found_any;
	logic [LW-1:0]      found_ord;
	logic [ORDER_W-1:0] cur_m1, ord_clip, carve_ord, unl_ord;
	logic [PW-1:0]      bud_split, bud_free;
	logic               carve_head;
	logic [NW-1:0]      cfg_sat;
	logic [NW-1:0]      req_pages, clip_pages, carve_pages;

	// saturate the managed page count to the pool
	assign cfg_sat = (32'(cfg_wdata) > POOL_PAGES) ? NIL : NW'(cfg_wdata);

	// smallest non-empty list at or above the request
	always_comb begin
		found_any = 1'b0;
		found_ord = '0;
		for (int i = 0; i < NLISTS; i++) begin
			if (!found_any && 32'(i) >= 32'(req_q) && head_q[i] != NIL) begin
				found_any = 1'b1;
				found_ord = LW'(i);
			end
		end
	end

	// largest order that still fits the carving remainder
	always_comb begin
		carve_ord = '0;
		for (int o = 0; o < NLISTS; o++) begin
			if ((32'd1 << o) <= 32'(carve_left_q)) carve_ord = ORDER_W'(o);
		end
	end

	assign carve_head  = (carve_left_q != '0) && ({1'b0, sweep_idx_q} == carve_next_q);
	assign carve_pages = NW'(1) << carve_ord;
	assign cur_m1      = cur_q - ORDER_W'(1);
	assign bud_split   = h_q ^ (PW'(1) << cur_m1);
	assign bud_free    = pg_q ^ (PW'(1) << ord_q);
	assign ord_clip    = (meta_rd_q.ord > MAXO) ? MAXO : meta_rd_q.ord;
	assign req_pages   = NW'(1) << req_q;
	assign clip_pages  = NW'(1) << ord_clip;
	assign unl_ord     = (cmd == CMD_A_UNLINK) ? cur_q : ord_q;

	// flags for the controller
	always_comb begin
		stat.sweep_last = (sweep_idx_q == PW'(POOL_PAGES - 1));
		stat.req_bad    = (req_q > MAXO);
		stat.none_found = !found_any;
		stat.split_more = (cur_q > req_q);
		stat.bud_in     = ({1'b0, bud_split} < managed_q);
		stat.page_out   = (32'(page_q) >= 32'(managed_q));
		stat.not_used   = !meta_rd_q.used;
		stat.can_bud    = (ord_q < MAXO) && ({1'b0, bud_free} < managed_q);
		stat.merge_ok   = !meta_rd_q.used && (meta_rd_q.ord == ord_q) && meta_rd_q.listed;
		stat.is_free    = (op_q == OP_FREE);
	end

	// memory read address
	always_comb begin
		rd_addr = '0;
		case (cmd)
			CMD_A_FIND:  rd_addr = head_q[found_ord][PW-1:0];
			CMD_F_CHECK: rd_addr = PW'(page_q);
			CMD_F_BUD:   rd_addr = bud_free;
			default:     rd_addr = '0;
		endcase
	end

	// memory write ports
	always_comb begin
		nx_we = 1'b0;
		nx_wa = '0;
		nx_wd = '0;
		pv_we = 1'b0;
		pv_wa = '0;
		pv_wd = '0;
		mt_we = 1'b0;
		mt_wa = '0;
		mt_wd = '0;
		case (cmd) inside
			CMD_SWEEP: begin
				mt_we = 1'b1;
				mt_wa = sweep_idx_q;
				if (carve_head) begin
					mt_wd = '{ord: carve_ord, used: 1'b0, listed: 1'b1};
					nx_we = 1'b1;
					nx_wa = sweep_idx_q;
					nx_wd = head_q[carve_ord[LW-1:0]];
					pv_we = 1'b1;
					pv_wa = sweep_idx_q;
					// only the top list holds more than one carved block
					if (carve_ord == MAXO && 32'(carve_left_q) >= (32'd2 << MAX_ORDER)) begin
						pv_wd = {1'b0, sweep_idx_q} + carve_pages;
					end else begin
						pv_wd = NIL;
					end
				end
			end
			CMD_A_UNLINK, CMD_F_TEST: begin
				if (cmd == CMD_A_UNLINK || stat.merge_ok) begin
					if (prev_rd_q != NIL) begin
						nx_we = 1'b1;
						nx_wa = prev_rd_q[PW-1:0];
						nx_wd = next_rd_q;
					end
					if (next_rd_q != NIL) begin
						pv_we = 1'b1;
						pv_wa = next_rd_q[PW-1:0];
						pv_wd = prev_rd_q;
					end
					if (cmd == CMD_F_TEST) begin
						mt_we = 1'b1;
						mt_wa = bud_free;
						mt_wd = '{ord: meta_rd_q.ord, used: 1'b0, listed: 1'b0};
					end
				end
			end
			CMD_A_SPLIT: begin
				if (!stat.split_more) begin
					mt_we = 1'b1;
					mt_wa = h_q;
					mt_wd = '{ord: req_q, used: 1'b1, listed: 1'b0};
				end
			end
			CMD_PUSH1: begin
				nx_we = 1'b1;
				nx_wa = pg_q;
				nx_wd = head_q[ord_q[LW-1:0]];
				pv_we = 1'b1;
				pv_wa = pg_q;
				pv_wd = NIL;
				mt_we = 1'b1;
				mt_wa = pg_q;
				mt_wd = '{ord: ord_q, used: 1'b0, listed: 1'b1};
			end
			CMD_PUSH2: begin
				if (hold_q != NIL) begin
					pv_we = 1'b1;
					pv_wa = hold_q[PW-1:0];
					pv_wd = {1'b0, pg_q};
				end
			end
			CMD_F_FREE: begin
				if (meta_rd_q.used) begin
					mt_we = 1'b1;
					mt_wa = PW'(page_q);
					mt_wd = '{ord: meta_rd_q.ord, used: 1'b0, listed: meta_rd_q.listed};
				end
			end
			default: begin
				nx_we = 1'b0;
			end
		endcase
	end

	// memory arrays, read data registered
	always_ff @(posedge clk) begin
		if (nx_we) next_mem[nx_wa] <= nx_wd;
		next_rd_q <= next_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pv_we) prev_mem[pv_wa] <= pv_wd;
		prev_rd_q <= prev_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (mt_we) meta_mem[mt_wa] <= mt_wd;
		meta_rd_q <= meta_mem[rd_addr];
	end

	// list heads, counts, totals and sweep state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			managed_q    <= NIL;
			free_q       <= NIL;
			used_q       <= '0;
			sweep_idx_q  <= '0;
			carve_next_q <= '0;
			carve_left_q <= NIL;
			for (int i = 0; i < NLISTS; i++) begin
				head_q[i]  <= NIL;
				count_q[i] <= '0;
			end
		end else if (cfg_we) begin
			managed_q    <= cfg_sat;
			free_q       <= cfg_sat;
			used_q       <= '0;
			sweep_idx_q  <= '0;
			carve_next_q <= '0;
			carve_left_q <= cfg_sat;
			for (int i = 0; i < NLISTS; i++) begin
				head_q[i]  <= NIL;
				count_q[i] <= '0;
			end
		end else begin
			case (cmd) inside
				CMD_SWEEP: begin
					sweep_idx_q <= sweep_idx_q + PW'(1);
					if (carve_head) begin
						head_q[carve_ord[LW-1:0]]  <= {1'b0, sweep_idx_q};
						count_q[carve_ord[LW-1:0]] <= count_q[carve_ord[LW-1:0]] + NW'(1);
						carve_next_q <= carve_next_q + carve_pages;
						carve_left_q <= carve_left_q - carve_pages;
					end
				end
				CMD_A_UNLINK, CMD_F_TEST: begin
					if (cmd == CMD_A_UNLINK || stat.merge_ok) begin
						if (prev_rd_q == NIL) head_q[unl_ord[LW-1:0]] <= next_rd_q;
						if (count_q[unl_ord[LW-1:0]] != '0) begin
							count_q[unl_ord[LW-1:0]] <= count_q[unl_ord[LW-1:0]] - NW'(1);
						end
					end
				end
				CMD_A_SPLIT: begin
					if (!stat.split_more) begin
						used_q <= used_q + req_pages;
						free_q <= free_q - req_pages;
					end
				end
				CMD_PUSH1: begin
					head_q[ord_q[LW-1:0]]  <= {1'b0, pg_q};
					count_q[ord_q[LW-1:0]] <= count_q[ord_q[LW-1:0]] + NW'(1);
				end
				CMD_F_FREE: begin
					if (meta_rd_q.used) begin
						used_q <= used_q - clip_pages;
						free_q <= free_q + clip_pages;
					end
				end
				default: begin
					free_q <= free_q;
				end
			endcase
		end
	end

	// item working registers and result
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				op_q   <= in_operation;
				req_q  <= in_order;
				page_q <= in_page_index;
			end
			CMD_A_FIND: begin
				cur_q <= ORDER_W'(found_ord);
				h_q   <= head_q[found_ord][PW-1:0];
				res_blk_q <= '0;
				if (stat.req_bad) res_status_q <= ST_ORDER_BIG;
				else if (!found_any) res_status_q <= ST_NO_BLOCK;
			end
			CMD_A_SPLIT: begin
				if (stat.split_more) begin
					cur_q <= cur_m1;
					pg_q  <= bud_split;
					ord_q <= cur_m1;
				end else begin
					res_status_q <= ST_OK;
					res_blk_q    <= h_q;
				end
			end
			CMD_PUSH1: begin
				hold_q <= head_q[ord_q[LW-1:0]];
			end
			CMD_PUSH2: begin
				if (op_q == OP_FREE) begin
					res_status_q <= ST_OK;
					res_blk_q    <= pg_q;
				end
			end
			CMD_F_CHECK: begin
				res_status_q <= ST_NOT_ALLOC;
				res_blk_q    <= '0;
			end
			CMD_F_FREE: begin
				ord_q <= ord_clip;
				pg_q  <= PW'(page_q);
			end
			CMD_F_TEST: begin
				if (stat.merge_ok) begin
					if (bud_free < pg_q) pg_q <= bud_free;
					ord_q <= ord_q + ORDER_W'(1);
				end
			end
			default: begin
				hold_q <= hold_q;
			end
		endcase
	end

	// result fields
	assign res_status      = res_status_q;
	assign res_block_index = PAGE_W'(res_blk_q);
	assign res_free_count  = COUNT_W'(free_q);
	assign res_used_count  = COUNT_W'(used_q);

	// page conservation: free and used always add up to the managed range
	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		32'(free_q) + 32'(used_q) == 32'(managed_q))
		else $error("free and used pages do not add up");

	// an allocated block is aligned to its size
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_A_SPLIT && !stat.split_more |->
		(h_q & ~({PW{1'b1}} << req_q)) == '0)
		else $error("allocated block not aligned");

	// a merge never climbs past the top order
	a_merge_top: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_F_TEST && stat.merge_ok |-> ord_q < MAXO)
		else $error("merge beyond top order");

endmodule

### hw/rtl/buddy_page_allocator_unit.sv
// buddy_page_allocator_unit: top level of the buddy page allocator
// depends on bpa_pkg, bpa_chan_if, bpa_ctrl and bpa_dp
// one item at a time; an alloc walks down its split levels and lists each upper half
//   that lies in the range, a free walks up its merge levels with a buddy test each
//   and then pushes the block; errors answer without any split or merge; the controller
//   returns to idle after each result transfer; the steps are set by the link and
//   metadata memories, one access each per step
// after reset and after each pool size write a clearing pass over all POOL_PAGES pages
//   rebuilds the free lists; no request is taken during it
module buddy_page_allocator_unit #(
	parameter int unsigned POOL_PAGES = bpa_pkg::POOL_PAGES_DEF,
	parameter int unsigned MAX_ORDER  = bpa_pkg::MAX_ORDER_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	bpa_cmd_if.sink                      cmd_ch,
	bpa_rsp_if.source                    rsp_ch,
	input  logic                         cfg_we,
	input  logic [bpa_pkg::COUNT_W-1:0]  cfg_wdata
);
	import bpa_pkg::*;

	cmd_t     cmd;
	dp_stat_t stat;

	// sequencer
	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.in_valid  (cmd_ch.valid),
		.in_free   (cmd_ch.operation),
		.out_ready (rsp_ch.ready),
		.stat      (stat),
		.cmd       (cmd),
		.in_ready  (cmd_ch.ready),
		.out_valid (rsp_ch.valid)
	);

	// lists, memories and counters
	bpa_dp #(
		.POOL_PAGES (POOL_PAGES),
		.MAX_ORDER  (MAX_ORDER)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_operation    (cmd_ch.operation),
		.in_order        (cmd_ch.order),
		.in_page_index   (cmd_ch.page_index),
		.stat            (stat),
		.res_status      (rsp_ch.status),
		.res_block_index (rsp_ch.block_index),
		.res_free_count  (rsp_ch.free_count),
		.res_used_count  (rsp_ch.used_count)
	);

endmodule

### verif/bpa_checker.sv
// bpa_checker: predicts each allocator result and compares it on the result channel
// depends on bpa_pkg and the channel interfaces in bpa_chan_if
module bpa_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	bpa_cmd_if                           cmd,
	bpa_rsp_if                           rsp,
	input  logic                         cfg_we,
	input  logic [bpa_pkg::COUNT_W-1:0]  cfg_wdata,
	output int                           errors,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import bpa_pkg::*;

	localparam int POOL = POOL_PAGES_DEF;
	localparam int TOP_ORD = MAX_ORDER_DEF;
	localparam logic [COUNT_W-1:0] NIL = COUNT_W'(POOL);

	typedef struct packed {
		status_t              status;
		logic [PAGE_W-1:0]    blk;
		logic [COUNT_W-1:0]   free_cnt;
		logic [COUNT_W-1:0]   used_cnt;
	} alloc_rsp_t;

	// shadow allocator state
	logic [COUNT_W-1:0] head_of [0:TOP_ORD];
	logic [COUNT_W-1:0] nxt [0:POOL-1];
	logic [COUNT_W-1:0] prv [0:POOL-1];
	logic [ORDER_W-1:0] blk_ord [0:POOL-1];
	logic               blk_used [0:POOL-1];
	logic               blk_listed [0:POOL-1];
	int                 pool_sz;
	int                 free_cnt;
	int                 used_cnt;
	alloc_rsp_t         expected_q[$];

	assign pending = expected_q.size();

	function automatic void list_push(int o, int pg);
		int h;
		h = head_of[o];
		nxt[pg] = COUNT_W'(h);
		prv[pg] = NIL;
		if (h < POOL) prv[h] = COUNT_W'(pg);
		head_of[o] = COUNT_W'(pg);
		blk_ord[pg] = ORDER_W'(o);
		blk_listed[pg] = 1'b1;
	endfunction

	function automatic void list_unlink(int o, int pg);
		int p;
		int n;
		p = prv[pg];
		n = nxt[pg];
		if (p < POOL) nxt[p] = COUNT_W'(n);
		else head_of[o] = COUNT_W'(n);
		if (n < POOL) prv[n] = COUNT_W'(p);
		nxt[pg] = NIL;
		prv[pg] = NIL;
		blk_listed[pg] = 1'b0;
	endfunction

	// carve the managed range into aligned blocks, largest first
	function automatic void carve_pool(int pages);
		int start;
		int left;
		int o;
		pool_sz = (pages > POOL) ? POOL : pages;
		for (int i = 0; i < POOL; i++) begin
			nxt[i] = '0;
			prv[i] = '0;
			blk_ord[i] = '0;
			blk_used[i] = 1'b0;
			blk_listed[i] = 1'b0;
		end
		for (int i = 0; i <= TOP_ORD; i++) head_of[i] = NIL;
		start = 0;
		left = pool_sz;
		while (left > 0) begin
			o = TOP_ORD;
			while ((1 << o) > left && o > 0) o--;
			list_push(o, start);
			start += 1 << o;
			left -= 1 << o;
		end
		free_cnt = pool_sz;
		used_cnt = 0;
	endfunction

	function automatic alloc_rsp_t predict_rsp(logic op, int req, int pg);
		alloc_rsp_t r;
		int cur;
		int h;
		int bud;
		int o;
		r.status = ST_OK;
		r.blk = '0;
		if (op == OP_ALLOC) begin
			if (req > TOP_ORD) begin
				r.status = ST_ORDER_BIG;
			end else begin
				cur = req;
				while (cur <= TOP_ORD && head_of[cur] >= POOL) cur++;
				if (cur > TOP_ORD) begin
					r.status = ST_NO_BLOCK;
				end else begin
					h = head_of[cur];
					list_unlink(cur, h);
					// split down, listing each upper half that lies in range
					while (cur > req) begin
						cur--;
						bud = h ^ (1 << cur);
						if (bud < pool_sz) begin
							blk_used[bud] = 1'b0;
							list_push(cur, bud);
						end
					end
					blk_ord[h] = ORDER_W'(req);
					blk_used[h] = 1'b1;
					used_cnt += 1 << req;
					free_cnt -= 1 << req;
					r.blk = PAGE_W'(h);
				end
			end
		end else begin
			if (pg >= pool_sz || !blk_used[pg]) begin
				r.status = ST_NOT_ALLOC;
			end else begin
				o = blk_ord[pg];
				if (o > TOP_ORD) o = TOP_ORD;
				blk_used[pg] = 1'b0;
				used_cnt -= 1 << o;
				free_cnt += 1 << o;
				// merge upward while the buddy is a free listed block of equal order
				while (o < TOP_ORD) begin
					bud = pg ^ (1 << o);
					if (bud >= pool_sz || blk_used[bud] || blk_ord[bud] != o ||
					    !blk_listed[bud]) break;
					list_unlink(o, bud);
					if (bud < pg) pg = bud;
					o++;
				end
				list_push(o, pg);
				r.blk = PAGE_W'(pg);
			end
		end
		r.free_cnt = COUNT_W'(free_cnt);
		r.used_cnt = COUNT_W'(used_cnt);
		return r;
	endfunction

	// watch both channels and the config port
	always @(posedge clk or negedge arst_n) begin
		alloc_rsp_t want;
		if (!arst_n) begin
			carve_pool(POOL);
			expected_q.delete();
			errors <= 0;
		end else begin
			if (cfg_we) carve_pool(int'(cfg_wdata));
			if (cmd.valid && cmd.ready)
				expected_q.push_back(predict_rsp(cmd.operation, int'(cmd.order),
					int'(cmd.page_index)));
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with nothing expected");
					errors <= errors + 1;
				end else begin
					want = expected_q.pop_front();
					if (rsp.status !== want.status ||
					    rsp.block_index !== want.blk ||
					    rsp.free_count !== want.free_cnt ||
					    rsp.used_count !== want.used_cnt) begin
						errors <= errors + 1;
						if (rsp.status !== want.status)
							$error("status: expected %0d, got %0d", want.status, rsp.status);
						if (rsp.block_index !== want.blk)
							$error("block_index: expected %0d, got %0d", want.blk,
								rsp.block_index);
						if (rsp.free_count !== want.free_cnt)
							$error("free_count: expected %0d, got %0d", want.free_cnt,
								rsp.free_count);
						if (rsp.used_count !== want.used_cnt)
							$error("used_count: expected %0d, got %0d", want.used_cnt,
								rsp.used_count);
					end
				end
			end
		end
	end

endmodule

### verif/testbench.sv
// testbench: drives alloc and free requests and pool size writes into the allocator
// depends on bpa_pkg, bpa_chan_if, buddy_page_allocator_unit and bpa_checker
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bpa_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [COUNT_W-1:0]  cfg_wdata;
	int                  errors;
	int                  pending;
	int                  cycles;
	int                  send_idle_pct;
	int                  recv_stall_pct;
	int                  item_cnt;
	logic                op_q[$];
	logic [PAGE_W-1:0]   live_pages[$];

	bpa_cmd_if cmd ();
	bpa_rsp_if rsp ();

	buddy_page_allocator_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cmd_ch(cmd), .rsp_ch(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	bpa_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .errors(errors), .pending(pending)
	);

	// clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("run stopped at cycle limit");
			$display("testbench NOT OK");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (arst_n) rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// remember allocated blocks so that frees mostly hit live blocks
	always @(posedge clk) begin
		logic op;
		if (cmd.valid && cmd.ready) op_q.push_back(cmd.operation);
		if (rsp.valid && rsp.ready && op_q.size() > 0) begin
			op = op_q.pop_front();
			if (op == OP_ALLOC && rsp.status == ST_OK) live_pages.push_back(rsp.block_index);
		end
	end

	// one request transfer, with random sender gaps in front
	task automatic send_req(logic op, int ord, int pg);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.operation <= op;
		cmd.order <= ORDER_W'(ord);
		cmd.page_index <= PAGE_W'(pg);
		do @(posedge clk); while (!cmd.ready);
		item_cnt++;
	endtask

	task automatic wait_drained();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_pool(int pages);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= COUNT_W'(pages);
		@(posedge clk);
		cfg_we <= 1'b0;
		live_pages.delete();
	endtask

	// free a live block on most calls if there is one, else a random page
	task automatic free_some();
		int k;
		int pg;
		if (live_pages.size() > 0 && $urandom_range(0, 99) < 80) begin
			k = $urandom_range(0, live_pages.size() - 1);
			pg = live_pages[k];
			live_pages.delete(k);
		end else begin
			pg = $urandom_range(0, 4095);
		end
		send_req(OP_FREE, 0, pg);
	endtask

	task automatic random_item();
		int ord;
		if ($urandom_range(0, 99) < 55) begin
			ord = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 4) : $urandom_range(0, 15);
			send_req(OP_ALLOC, ord, $urandom_range(0, 4095));
		end else begin
			free_some();
		end
	endtask

	initial begin
		int pools[7];
		pools = '{37, 0, 8191, 1, 100, 4096, 0};
		pools[6] = $urandom_range(2, 4096);
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cycles = 0;
		item_cnt = 0;
		cmd.valid = 1'b0;
		cmd.operation = OP_ALLOC;
		cmd.order = '0;
		cmd.page_index = '0;
		rsp.ready = 1'b0;
		send_idle_pct = 16;
		recv_stall_pct = 54;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: order extremes, exhaustion, bad frees, merges
		send_req(OP_ALLOC, 0, 0);
		send_req(OP_ALLOC, 11, 0);
		send_req(OP_ALLOC, 15, 4095);
		send_req(OP_ALLOC, 10, 0);
		send_req(OP_ALLOC, 10, 0);
		send_req(OP_ALLOC, 10, 0);
		send_req(OP_ALLOC, 10, 0);
		send_req(OP_FREE, 0, 4095);
		send_req(OP_FREE, 0, 1);
		repeat (3) free_some();
		send_req(OP_ALLOC, 3, 0);
		send_req(OP_ALLOC, 1, 0);
		send_req(OP_ALLOC, 9, 0);
		repeat (4) free_some();
		send_req(OP_FREE, 0, 2048);
		send_req(OP_ALLOC, 10, 0);

		// random phases over several pool sizes and idling mixes
		for (int p = 0; p < 7; p++) begin
			set_pool(pools[p]);
			send_idle_pct = (p < 2) ? 16 : (p < 4) ? 54 : 0;
			recv_stall_pct = (p < 2) ? 54 : (p < 4) ? 16 : 0;
			for (int i = 0; i < 104; i++) begin
				if (p == 2 && i == 50) wait_drained();
				random_item();
			end
		end

		wait_drained();
		repeat (50) @(posedge clk);
		$display("%0d requests over 8 pool sizes (empty, one page, saturated, full)",
			item_cnt);
		$display("with sender gaps and receiver stalls in both proportions");
		if (errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_chan_if.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/bpa_dp.sv
hw/rtl/buddy_page_allocator_unit.sv
verif/bpa_checker.sv
verif/testbench.sv
